>>> hw/rtl/ordered_integer_set_table_defines.svh
// Assertion helpers for the checker of the set table.
`ifndef ORDERED_INTEGER_SET_TABLE_DEFINES_SVH
`define ORDERED_INTEGER_SET_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set table check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set table check failed");

`endif

>>> hw/rtl/ois_pkg.sv
package ois_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 3;

  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic [VAL_W-1:0] key;       // value compared against every slot
    logic [POS_W-1:0] pos;       // read position
    logic [CNT_W-1:0] count;     // current member count
    logic             wr;        // append wr_value at slot count
    logic             shift;     // close the gap left by the matching slot
    logic [VAL_W-1:0] wr_value;
  } ois_ctrl_t;

endpackage

>>> hw/rtl/ois_ifs.sv
interface ois_in_if;
  import ois_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink (input valid, action, value, position, output ready);
endinterface

interface ois_out_if;
  import ois_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    full_reject;
  logic [CNT_W-1:0]        member_count;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, hit, full_reject, member_count, read_value, input ready);
  modport sink (input valid, hit, full_reject, member_count, read_value, output ready);
endinterface

>>> hw/rtl/ois_cell.sv
module ois_cell
  import ois_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] cell_idx,
  input  ois_ctrl_t        ctrl,
  input  logic             shift_in,
  input  logic [VAL_W-1:0] next_entry,
  output logic             shift_out,
  output logic [VAL_W-1:0] entry_out,
  output logic             match_out,
  output logic [VAL_W-1:0] rd_out
);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic             match_r, match_nxt;
  logic [VAL_W-1:0] rd_r, rd_nxt;
  logic             live;

  assign live      = CNT_W'(cell_idx) < ctrl.count;
  assign match_nxt = live && (entry_r == ctrl.key);
  assign rd_nxt    = (CNT_W'(cell_idx) == CNT_W'(ctrl.pos)) ? entry_r : '0;

  // Pass the "at or after the removed slot" flag down the chain.
  assign shift_out = shift_in | match_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.wr && (CNT_W'(cell_idx) == ctrl.count)) begin
      entry_nxt = ctrl.wr_value;
    end else if (ctrl.shift && shift_out) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry_out = entry_r;
  assign match_out = match_r;
  assign rd_out    = rd_r;

endmodule

>>> hw/rtl/ois_chain.sv
module ois_chain
  import ois_pkg::*;
(
  input  logic             clk,
  input  ois_ctrl_t        ctrl,
  output logic             found,
  output logic [VAL_W-1:0] rd_value
);

  logic [CAPACITY:0]           shift_link;
  logic [VAL_W-1:0]            entry_w [CAPACITY+1];
  logic [CAPACITY-1:0]         match_w;
  logic [VAL_W-1:0]            rd_w    [CAPACITY];

  assign shift_link[0]     = 1'b0;
  assign entry_w[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ois_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .ctrl       (ctrl),
      .shift_in   (shift_link[i]),
      .next_entry (entry_w[i+1]),
      .shift_out  (shift_link[i+1]),
      .entry_out  (entry_w[i]),
      .match_out  (match_w[i]),
      .rd_out     (rd_w[i])
    );
  end

  assign found = |match_w;

  // At most one cell drives a nonzero read value.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rd_w[i];
    end
  end

endmodule

>>> hw/rtl/ordered_integer_set_table.sv
// A request waits in the request registers until it commits into the output register;
// no new one is taken before then. Every cell compares its slot in the accept cycle, and
// the cell chain commits the append or the shift-down in the commit cycle that follows.
// A result the receiver has not taken holds off the commit, and the input with it.
// Reset (synchronous, rst_n low): member count, state and output valid clear;
// slot contents are left as they are and only slots below the count are ever read.
module ordered_integer_set_table
  import ois_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ois_in_if.sink    in_req,
  ois_out_if.source out_rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ACT_W-1:0] act_r;
  logic [VAL_W-1:0] value_r;
  logic [POS_W-1:0] pos_r;

  logic             out_valid_r, out_valid_nxt;
  logic             hit_r, hit_nxt;
  logic             rej_r, rej_nxt;
  logic [CNT_W-1:0] cnt_out_r, cnt_out_nxt;
  logic [VAL_W-1:0] rd_out_r, rd_out_nxt;

  logic             accept;
  logic             commit;
  logic             found;
  logic [VAL_W-1:0] chain_rd;
  logic             do_add;
  logic             do_remove;
  ois_ctrl_t        ctrl;

  // Take a request only when idle; the output register parts the two sides.
  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  // Commit once the output register is free or being drained.
  assign commit       = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  assign do_add    = commit && (act_r == ACT_ADD) && !found && (count_r < CAP_COUNT);
  assign do_remove = commit && (act_r == ACT_REMOVE) && found;

  // Cells compare against the incoming request in the accept cycle, so the
  // match flags are ready in the commit cycle. While the request waits for
  // the output register, keep comparing against the held copy.
  always_comb begin
    ctrl          = '0;
    ctrl.key      = (state_r == S_IDLE) ? in_req.value : value_r;
    ctrl.pos      = (state_r == S_IDLE) ? in_req.position : pos_r;
    ctrl.count    = count_r;
    ctrl.wr       = do_add;
    ctrl.shift    = do_remove;
    ctrl.wr_value = value_r;
  end

  ois_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .found    (found),
    .rd_value (chain_rd)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    hit_nxt       = hit_r;
    rej_nxt       = rej_r;
    cnt_out_nxt   = cnt_out_r;
    rd_out_nxt    = rd_out_r;

    if (accept) begin
      state_nxt = S_EXEC;
    end

    if (commit) begin
      state_nxt   = S_IDLE;
      hit_nxt     = 1'b0;
      rej_nxt     = 1'b0;
      rd_out_nxt  = '0;
      case (act_r)
        ACT_ADD: begin
          if (!found) begin
            if (count_r < CAP_COUNT) begin
              count_nxt = count_r + 1'b1;
              hit_nxt   = 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
          end
        end
        ACT_REMOVE: begin
          if (found) begin
            count_nxt = count_r - 1'b1;
            hit_nxt   = 1'b1;
          end
        end
        ACT_CONTAINS: begin
          hit_nxt = found;
        end
        ACT_CLEAR: begin
          count_nxt = '0;
          hit_nxt   = 1'b1;
        end
        ACT_READ: begin
          if (CNT_W'(pos_r) < count_r) begin
            hit_nxt    = 1'b1;
            rd_out_nxt = chain_rd;
          end
        end
        default: begin
          // Unknown action: report the count, change nothing.
        end
      endcase
      cnt_out_nxt   = count_nxt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_req.action;
      value_r <= in_req.value;
      pos_r   <= in_req.position;
    end
    hit_r     <= hit_nxt;
    rej_r     <= rej_nxt;
    cnt_out_r <= cnt_out_nxt;
    rd_out_r  <= rd_out_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.hit          = hit_r;
  assign out_rsp.full_reject  = rej_r;
  assign out_rsp.member_count = cnt_out_r;
  assign out_rsp.read_value   = rd_out_r;

endmodule

>>> hw/rtl/ois_checker.sv
`include "ordered_integer_set_table_defines.svh"

module ois_checker
  import ois_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_hit,
  input logic             out_full_reject,
  input logic [CNT_W-1:0] out_member_count,
  input logic [VAL_W-1:0] out_read_value
);

  `OIS_ASSERT_NOW(a_count_bound, out_valid, out_member_count <= CAP_COUNT)
  `OIS_ASSERT_NOW(a_reject_full, out_valid && out_full_reject,
                  !out_hit && (out_member_count == CAP_COUNT))
  `OIS_ASSERT_NOW(a_read_needs_hit, out_valid && (out_read_value != '0), out_hit)
  `OIS_ASSERT_NEXT(a_no_back_to_back, in_valid && in_ready, !in_ready)
  `OIS_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)

endmodule

bind ordered_integer_set_table ois_checker u_ois_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_hit          (out_rsp.hit),
  .out_full_reject  (out_rsp.full_reject),
  .out_member_count (out_rsp.member_count),
  .out_read_value   (out_rsp.read_value)
);

>>> tb/sv/tb_ordered_integer_set_table.sv
module tb_ordered_integer_set_table;
  import ois_pkg::*;

  // Action codes five to seven are not defined by the block; it must ignore them.
  localparam logic [ACT_W-1:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI  = 3'd7;

  localparam logic signed [VAL_W-1:0] V_MIN  = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] V_MAX  = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] V_NEG1 = -32'sd1;
  localparam logic signed [VAL_W-1:0] V_ZERO = 32'sd0;
  localparam logic signed [VAL_W-1:0] V_A5   = 32'sha5a5_a5a5;
  localparam logic signed [VAL_W-1:0] V_5A   = 32'sh5a5a_5a5a;

  localparam int POOL_SIZE   = 96;   // a bit wider than capacity, so adds hit and miss
  localparam int PHASE_ITEMS = 270;  // random requests per idling phase, fill burst aside
  localparam int HOLD_CYCLES = 200;  // long receiver hold-off

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } set_req_t;

  typedef struct packed {
    logic                    hit;
    logic                    full_reject;
    logic [CNT_W-1:0]        member_count;
    logic signed [VAL_W-1:0] read_value;
  } set_rsp_t;

  // One directed row: the request, and a hand-typed result where it is obvious.
  typedef struct packed {
    set_req_t req;
    logic     typed;
    set_rsp_t rsp;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Directed requests. Rows with typed = 0 are checked against the set predictor.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty set right after reset: read, contains, remove all miss; clear hits
    '{'{ACT_READ,     V_ZERO, 6'd0},  1'b1, '{1'b0, 1'b0, 7'd0, V_ZERO}},
    '{'{ACT_CONTAINS, V_ZERO, 6'd0},  1'b1, '{1'b0, 1'b0, 7'd0, V_ZERO}},
    '{'{ACT_REMOVE,   32'sd5, 6'd0},  1'b1, '{1'b0, 1'b0, 7'd0, V_ZERO}},
    '{'{ACT_CLEAR,    V_ZERO, 6'd0},  1'b1, '{1'b1, 1'b0, 7'd0, V_ZERO}},
    // extremes of the value range go in at the tail
    '{'{ACT_ADD,      V_MIN,  6'd0},  1'b1, '{1'b1, 1'b0, 7'd1, V_ZERO}},
    '{'{ACT_ADD,      V_MAX,  6'd63}, 1'b1, '{1'b1, 1'b0, 7'd2, V_ZERO}},
    '{'{ACT_ADD,      V_ZERO, 6'd0},  1'b1, '{1'b1, 1'b0, 7'd3, V_ZERO}},
    '{'{ACT_ADD,      V_NEG1, 6'd0},  1'b1, '{1'b1, 1'b0, 7'd4, V_ZERO}},
    // add of a value already present changes nothing
    '{'{ACT_ADD,      V_MIN,  6'd0},  1'b1, '{1'b0, 1'b0, 7'd4, V_ZERO}},
    '{'{ACT_ADD,      V_5A,   6'd21}, 1'b0, '0},
    '{'{ACT_ADD,      V_A5,   6'd42}, 1'b0, '0},
    '{'{ACT_CONTAINS, V_MAX,  6'd0},  1'b1, '{1'b1, 1'b0, 7'd6, V_ZERO}},
    '{'{ACT_READ,     V_ZERO, 6'd0},  1'b1, '{1'b1, 1'b0, 7'd6, V_MIN}},
    '{'{ACT_READ,     V_ZERO, 6'd63}, 1'b1, '{1'b0, 1'b0, 7'd6, V_ZERO}},
    // remove from the middle, then check the later members moved down in order
    '{'{ACT_REMOVE,   V_ZERO, 6'd0},  1'b0, '0},
    '{'{ACT_READ,     V_ZERO, 6'd2},  1'b0, '0},
    '{'{ACT_READ,     V_ZERO, 6'd5},  1'b0, '0},
    '{'{ACT_REMOVE,   V_MIN,  6'd0},  1'b0, '0},
    '{'{ACT_REMOVE,   V_MIN,  6'd0},  1'b0, '0},
    // undefined actions leave everything alone
    '{'{ACT_RSVD_LO,  V_MAX,  6'd63}, 1'b1, '{1'b0, 1'b0, 7'd4, V_ZERO}},
    '{'{ACT_RSVD_MID, V_MIN,  6'd0},  1'b1, '{1'b0, 1'b0, 7'd4, V_ZERO}},
    '{'{ACT_RSVD_HI,  V_NEG1, 6'd1},  1'b1, '{1'b0, 1'b0, 7'd4, V_ZERO}},
    '{'{ACT_READ,     V_ZERO, 6'd3},  1'b0, '0},
    '{'{ACT_CLEAR,    V_ZERO, 6'd0},  1'b1, '{1'b1, 1'b0, 7'd0, V_ZERO}},
    '{'{ACT_CONTAINS, V_MAX,  6'd0},  1'b1, '{1'b0, 1'b0, 7'd0, V_ZERO}}
  };

  logic clk = 1'b0;
  logic rst_n;

  ois_in_if  req_if ();
  ois_out_if rsp_if ();

  ordered_integer_set_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  always #1 clk = ~clk;

  // Predicted contents of the set, in membership order.
  logic signed [VAL_W-1:0] set_slots [CAPACITY];
  int                      set_size;

  // Results the block still owes, oldest first.
  set_rsp_t expected_rsp [$];

  logic signed [VAL_W-1:0] value_pool [POOL_SIZE];

  int snd_idle_pct;
  int rcv_idle_pct;
  bit long_hold_req;
  int rsp_hold_left;
  int n_fail;

  // Apply one request to the predicted set and return the result it must produce.
  function automatic set_rsp_t apply_to_set(input set_req_t r);
    set_rsp_t o;
    int       at;
    o  = '0;
    at = -1;
    for (int i = 0; i < set_size; i++) begin
      if (at < 0 && set_slots[i] == r.value) at = i;
    end
    case (r.action)
      ACT_ADD: begin
        if (at < 0) begin
          if (set_size < CAPACITY) begin
            set_slots[set_size] = r.value;
            set_size++;
            o.hit = 1'b1;
          end else begin
            o.full_reject = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        if (at >= 0) begin
          // close the gap, keeping the order of the later members
          for (int j = at; j + 1 < set_size; j++) set_slots[j] = set_slots[j + 1];
          set_size--;
          o.hit = 1'b1;
        end
      end
      ACT_CONTAINS: o.hit = (at >= 0);
      ACT_CLEAR: begin
        set_size = 0;
        o.hit    = 1'b1;
      end
      ACT_READ: begin
        if (int'(r.position) < set_size) begin
          o.read_value = set_slots[r.position];
          o.hit        = 1'b1;
        end
      end
      default: ;
    endcase
    o.member_count = CNT_W'(set_size);
    return o;
  endfunction

  // Draw a random request, biased toward members and a small value pool so that
  // adds of present values, remove hits and valid reads are frequent.
  function automatic set_req_t rand_req();
    set_req_t    r;
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 40)      r.action = ACT_ADD;
    else if (dice < 55) r.action = ACT_REMOVE;
    else if (dice < 70) r.action = ACT_CONTAINS;
    else if (dice < 72) r.action = ACT_CLEAR;
    else if (dice < 95) r.action = ACT_READ;
    else                r.action = ACT_W'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));

    if (set_size > 0 && $urandom_range(1) == 1)
      r.value = set_slots[$urandom_range(set_size - 1)];
    else if ($urandom_range(9) < 6)
      r.value = value_pool[$urandom_range(POOL_SIZE - 1)];
    else
      r.value = $urandom();

    if (set_size > 0 && $urandom_range(3) != 0)
      r.position = POS_W'($urandom_range(set_size - 1));
    else
      r.position = POS_W'($urandom());
    return r;
  endfunction

  // Offer one request, idling first at the sender's rate, and hold it until accepted.
  // On acceptance, queue the typed result if given, else the predicted one.
  task automatic offer_req(input set_req_t r, input logic typed, input set_rsp_t typed_rsp);
    set_rsp_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= r.action;
    req_if.value    <= r.value;
    req_if.position <= r.position;
    do @(posedge clk); while (!req_if.ready);
    pred = apply_to_set(r);
    expected_rsp.push_back(typed ? typed_rsp : pred);
  endtask

  // Clear, add fresh values up to capacity, then hit the full-set cases:
  // new values refused, a present value ignored, the last slot read, and a
  // removal at or below the middle slot that shifts the later members down.
  task automatic fill_to_capacity();
    set_req_t r;
    r        = '0;
    r.action = ACT_CLEAR;
    offer_req(r, 1'b0, '0);
    r.action = ACT_ADD;
    while (set_size < CAPACITY) begin
      r.value = $urandom();
      offer_req(r, 1'b0, '0);
    end
    repeat (3) begin
      r.value = $urandom();
      offer_req(r, 1'b0, '0);
    end
    r.value = set_slots[$urandom_range(CAPACITY - 1)];
    offer_req(r, 1'b0, '0);
    r.action   = ACT_READ;
    r.position = POS_W'(CAPACITY - 1);
    offer_req(r, 1'b0, '0);
    r.action = ACT_REMOVE;
    r.value  = set_slots[$urandom_range(CAPACITY / 2)];
    offer_req(r, 1'b0, '0);
  endtask

  // One idling phase of random traffic with a fill burst in the middle.
  // Drop valid at the end and hold off until the block has answered everything.
  task automatic run_phase(input int snd_pct, input int rcv_pct, input bit with_hold);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    if (with_hold) long_hold_req = 1'b1;
    repeat (PHASE_ITEMS / 2) offer_req(rand_req(), 1'b0, '0);
    fill_to_capacity();
    repeat (PHASE_ITEMS / 2) offer_req(rand_req(), 1'b0, '0);
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  // Result side: drive ready at the receiver's idle rate, or hold it low for a
  // long stretch when asked, so the block backs up into its input.
  initial begin : rsp_sink
    rsp_if.ready  <= 1'b0;
    rsp_hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_hold_left = HOLD_CYCLES;
      end
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : rsp_check
    set_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
          n_fail++;
        end
        if (rsp_if.full_reject !== want.full_reject) begin
          $error("full_reject: expected %0d, got %0d", want.full_reject, rsp_if.full_reject);
          n_fail++;
        end
        if (rsp_if.member_count !== want.member_count) begin
          $error("member_count: expected %0d, got %0d", want.member_count,
                 rsp_if.member_count);
          n_fail++;
        end
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_if.read_value);
          n_fail++;
        end
      end
    end
  end

  initial begin : stimulus
    int guard;
    n_fail          = 0;
    set_size        = 0;
    snd_idle_pct    = 0;
    rcv_idle_pct    = 0;
    long_hold_req   = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.action   <= ACT_ADD;
    req_if.value    <= '0;
    req_if.position <= '0;

    // Seed the pool with random values and the extremes.
    for (int k = 0; k < POOL_SIZE; k++) value_pool[k] = $urandom();
    value_pool[0] = V_MIN;
    value_pool[1] = V_MAX;
    value_pool[2] = V_ZERO;
    value_pool[3] = V_NEG1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the first idling mix.
    snd_idle_pct = 38;
    rcv_idle_pct = 77;
    for (int i = 0; i < DIR_ROWS; i++)
      offer_req(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);

    // Sender sparse / receiver sparse, swapped, then full speed with a long
    // receiver hold-off at the start so the block stalls its input.
    run_phase(38, 77, 1'b0);
    run_phase(77, 38, 1'b0);
    run_phase(0, 0, 1'b1);

    // run_phase already drained; wait, with a guard, for anything stray.
    guard = 0;
    while (expected_rsp.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d results never arrived", expected_rsp.size());
      n_fail++;
    end

    if (n_fail == 0) $display("PASS ordered_integer_set_table");
    else $display("FAIL ordered_integer_set_table");
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of this.
  initial begin : watchdog
    #600000;
    $display("FAIL ordered_integer_set_table");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ois_pkg.sv
hw/rtl/ois_ifs.sv
hw/rtl/ois_cell.sv
hw/rtl/ois_chain.sv
hw/rtl/ordered_integer_set_table.sv
hw/rtl/ois_checker.sv
tb/sv/tb_ordered_integer_set_table.sv
